// File: rtl/core/async_cellular_automaton_coverage_core_macros.svh
// Assertion macros for the automaton coverage core checker
`ifndef ASYNC_CELLULAR_AUTOMATON_COVERAGE_CORE_MACROS_SVH
`define ASYNC_CELLULAR_AUTOMATON_COVERAGE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ACAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acac: same-cycle property failed");

// next-cycle implication, clocked on clk, off during reset
`define ACAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acac: next-cycle property failed");

`endif

// File: rtl/core/acac_pkg.sv
// Shared constants for the automaton coverage core
`default_nettype none

package acac_pkg;

  localparam int CELL_COUNT_W = 4;
  localparam int RULE_W       = 8;
  localparam int STEP_W       = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 14;
  localparam int MIN_CELLS    = 3;
  localparam int OUTQ_DEPTH   = 3;

  localparam logic [CELL_COUNT_W-1:0] CELL_COUNT_RST = 4'd10;
  localparam logic [RULE_W-1:0]       RULE_RST       = 8'd0;
  localparam logic [STEP_W-1:0]       STEP_LIMIT_RST = 14'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_NUMBER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/acac_map.sv
// Visited bitmap memory with row-wide clearing sweep
`default_nettype none

module acac_map #(
  parameter int ROW_LG  = 5,
  parameter int ROWS_LG = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr_start,
  input  logic                   rd_en,
  input  logic [ROWS_LG-1:0]     rd_row,
  output logic [(1<<ROW_LG)-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [ROWS_LG-1:0]     wr_row,
  input  logic [(1<<ROW_LG)-1:0] wr_data,
  output logic                   busy
);

  localparam int ROW_W = 1 << ROW_LG;
  localparam int ROWS  = 1 << ROWS_LG;

  logic [ROW_W-1:0]   mem [ROWS];
  logic [ROWS_LG-1:0] clr_ptr_r, clr_ptr_nxt;
  logic               busy_r, busy_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    clr_ptr_nxt = clr_ptr_r;
    if (clr_start) begin
      busy_nxt    = 1'b1;
      clr_ptr_nxt = '0;
    end else if (busy_r) begin
      clr_ptr_nxt = clr_ptr_r + ROWS_LG'(1);
      if (clr_ptr_r == {ROWS_LG{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_ptr_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_ptr_r <= clr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_ptr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// File: rtl/core/acac_outq.sv
// Three-word result queue in front of the output channel
`default_nettype none

module acac_outq #(
  parameter int W = 41
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic [1:0]   count,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_data
);

  localparam int DEPTH = acac_pkg::OUTQ_DEPTH;

  logic [W-1:0] entry_r [DEPTH];
  logic [1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_data  = entry_r[rd_ptr_r];
  assign count   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/acac_step.sv
// Step pipeline: next ring, bitmap read-modify-write, counters and flags
`default_nettype none

module acac_step #(
  parameter int MAX_CELLS = 12,
  parameter int ROW_LG    = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_CELLS+1)-1:0]        n_eff,
  input  logic [acac_pkg::RULE_W-1:0]           rule,
  input  logic [acac_pkg::STEP_W-1:0]           lim_eff,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [MAX_CELLS-1:0]                  in_start,
  input  logic [MAX_CELLS-1:0]                  in_mask,
  input  logic                                  map_busy,
  output logic                                  map_clr,
  output logic                                  map_rd_en,
  output logic [MAX_CELLS-ROW_LG-1:0]           map_rd_row,
  input  logic [(1<<ROW_LG)-1:0]                map_rd_data,
  output logic                                  map_wr_en,
  output logic [MAX_CELLS-ROW_LG-1:0]           map_wr_row,
  output logic [(1<<ROW_LG)-1:0]                map_wr_data,
  input  logic [1:0]                            q_cnt,
  output logic                                  push,
  output logic [2*MAX_CELLS+acac_pkg::STEP_W+2:0] push_data
);

  localparam int N_W    = $clog2(MAX_CELLS + 1);
  localparam int IDX_W  = $clog2(MAX_CELLS);
  localparam int CNT_W  = MAX_CELLS + 1;
  localparam int STEP_W = acac_pkg::STEP_W;
  localparam int ROW_W  = 1 << ROW_LG;

  logic [MAX_CELLS-1:0] mask_n;
  logic [MAX_CELLS-1:0] base, base_m, lft, rgt, nxt_cells, upd, s_step, s0;
  logic [N_W-1:0]       n_m1;
  logic                 c_top, l_bit;
  logic [2:0]           nbh;
  logic                 accept, is_step;

  logic                 st1_valid_r, st1_valid_nxt;
  logic                 st1_load_r, st1_load_nxt;
  logic [MAX_CELLS-1:0] st1_s_r, st1_s_nxt;
  logic                 fwd_hit_r, fwd_hit_nxt;
  logic [ROW_W-1:0]     fwd_row_r;
  logic                 st1_active;

  logic [MAX_CELLS-1:0] ring_r, ring_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_inc, full;
  logic [STEP_W-1:0]    steps_r, steps_nxt, steps_inc;
  logic                 fin_r, fin_nxt;
  logic [ROW_W-1:0]     row_q, bit_sel;
  logic                 bit_set, cov, exh;

  assign mask_n  = ~({MAX_CELLS{1'b1}} << n_eff);
  assign full    = CNT_W'(1) << n_eff;
  assign is_step = (in_op == acac_pkg::OP_STEP);

  assign st1_active = st1_valid_r && !st1_load_r && !fin_r;
  assign in_ready   = !map_busy && !(st1_valid_r && st1_load_r) &&
                      ((3'(st1_valid_r) + 3'(q_cnt)) <= 3'd2);
  assign accept     = in_valid && in_ready;

  // next ring from the state the item in flight leaves behind
  assign base   = st1_active ? st1_s_r : ring_r;
  assign base_m = base & mask_n;
  assign n_m1   = n_eff - N_W'(1);
  assign c_top  = base_m[n_m1[IDX_W-1:0]];
  assign lft    = {base_m[0], base_m[MAX_CELLS-1:1]};
  assign rgt    = {base_m[MAX_CELLS-2:0], c_top};

  always_comb begin
    nxt_cells = '0;
    l_bit     = 1'b0;
    nbh       = '0;
    for (int b = 0; b < MAX_CELLS; b++) begin
      l_bit        = (n_m1 == N_W'(b)) ? base_m[0] : lft[b];
      nbh          = {l_bit, base_m[b], rgt[b]};
      nxt_cells[b] = rule[nbh];
    end
  end

  assign upd    = in_mask & mask_n;
  assign s_step = ((base_m & ~upd) | (nxt_cells & upd)) & mask_n;
  assign s0     = is_step ? s_step : (in_start & mask_n);

  assign map_rd_en  = accept && is_step;
  assign map_rd_row = s0[MAX_CELLS-1:ROW_LG];

  // bitmap read-modify-write, forward the row written in the previous cycle
  assign row_q       = fwd_hit_r ? fwd_row_r : map_rd_data;
  assign bit_sel     = ROW_W'(1) << st1_s_r[ROW_LG-1:0];
  assign bit_set     = |(row_q & bit_sel);
  assign map_wr_en   = st1_active;
  assign map_wr_row  = st1_s_r[MAX_CELLS-1:ROW_LG];
  assign map_wr_data = row_q | bit_sel;
  assign map_clr     = st1_valid_r && st1_load_r;

  assign st1_valid_nxt = accept;
  assign st1_load_nxt  = accept ? !is_step : st1_load_r;
  assign st1_s_nxt     = accept ? s0 : st1_s_r;
  assign fwd_hit_nxt   = map_rd_en && st1_active && (map_rd_row == map_wr_row);

  assign cnt_inc   = cnt_r + CNT_W'(!bit_set);
  assign steps_inc = steps_r + STEP_W'(1);

  always_comb begin
    ring_nxt  = ring_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    fin_nxt   = fin_r;
    if (st1_valid_r) begin
      if (st1_load_r) begin
        ring_nxt  = st1_s_r;
        cnt_nxt   = '0;
        steps_nxt = '0;
        fin_nxt   = 1'b0;
      end else if (!fin_r) begin
        ring_nxt  = st1_s_r;
        cnt_nxt   = cnt_inc;
        steps_nxt = steps_inc;
        fin_nxt   = (cnt_inc >= full) || (steps_inc >= lim_eff);
      end
    end
  end

  assign cov       = fin_nxt && (cnt_nxt >= full);
  assign exh       = fin_nxt && !cov;
  assign push      = st1_valid_r;
  assign push_data = {exh, cov, steps_nxt, cnt_nxt, ring_nxt & mask_n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
      st1_load_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      ring_r      <= '0;
      cnt_r       <= '0;
      steps_r     <= '0;
      fin_r       <= 1'b0;
    end else begin
      st1_valid_r <= st1_valid_nxt;
      st1_load_r  <= st1_load_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
      ring_r      <= ring_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st1_s_r   <= st1_s_nxt;
    fwd_row_r <= map_wr_data;
  end

endmodule

`default_nettype wire

// File: rtl/core/async_cellular_automaton_coverage_core.sv
// A result word passes through the stage-one register and the output queue on its way to out_tdata.
// Throughput: one step word per cycle while the output queue has room; the bitmap
// read-modify-write forwards the row written in the previous cycle, so steps
// follow back to back. A load word starts a sweep over the 2**(MAX_CELLS-ROW_LG) bitmap
// rows (128 at MAX_CELLS = 12), with in_tready low; reset starts the same sweep.
// Reset (rst_n low, synchronous) restores the register defaults and clears all counters.
`default_nettype none

module async_cellular_automaton_coverage_core #(
  parameter int MAX_CELLS = 12,
  localparam int IN_DW    = ((2 * MAX_CELLS + 7) / 8) * 8,
  localparam int OUT_RAW  = 2 * MAX_CELLS + acac_pkg::STEP_W + 3,
  localparam int OUT_DW   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DW-1:0]                 in_tdata,   // start_cells, update_mask
  input  logic                             in_tuser,   // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_DW-1:0]                out_tdata,  // cells, visited_count,
                                                       // steps_taken, covered, exhausted
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [acac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int N_W     = $clog2(MAX_CELLS + 1);
  localparam int ROW_LG  = (MAX_CELLS >= 6) ? 5 : MAX_CELLS - 1;
  localparam int ROWS_LG = MAX_CELLS - ROW_LG;
  localparam int ROW_W   = 1 << ROW_LG;
  localparam int CC_W    = acac_pkg::CELL_COUNT_W;
  localparam int RULE_W  = acac_pkg::RULE_W;
  localparam int STEP_W  = acac_pkg::STEP_W;

  logic [CC_W-1:0]   cell_count_r, cell_count_nxt;
  logic [RULE_W-1:0] rule_r, rule_nxt;
  logic [STEP_W-1:0] limit_r, limit_nxt;
  logic [N_W-1:0]    n_eff;
  logic [STEP_W-1:0] lim_eff;

  logic                 map_busy, map_clr, map_rd_en, map_wr_en;
  logic [ROWS_LG-1:0]   map_rd_row, map_wr_row;
  logic [ROW_W-1:0]     map_rd_data, map_wr_data;
  logic [1:0]           q_cnt;
  logic                 push;
  logic [OUT_RAW-1:0]   push_data, q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cell_count_nxt = cell_count_r;
    rule_nxt       = rule_r;
    limit_nxt      = limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acac_pkg::CFG_CELL_COUNT:  cell_count_nxt = cfg_data[CC_W-1:0];
        acac_pkg::CFG_RULE_NUMBER: rule_nxt       = cfg_data[RULE_W-1:0];
        acac_pkg::CFG_STEP_LIMIT:  limit_nxt      = cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= acac_pkg::CELL_COUNT_RST;
      rule_r       <= acac_pkg::RULE_RST;
      limit_r      <= acac_pkg::STEP_LIMIT_RST;
    end else begin
      cell_count_r <= cell_count_nxt;
      rule_r       <= rule_nxt;
      limit_r      <= limit_nxt;
    end
  end

  // clamp the ring size, a zero limit acts as one
  always_comb begin
    if (int'(cell_count_r) < acac_pkg::MIN_CELLS) begin
      n_eff = N_W'(acac_pkg::MIN_CELLS);
    end else if (int'(cell_count_r) > MAX_CELLS) begin
      n_eff = N_W'(MAX_CELLS);
    end else begin
      n_eff = N_W'(cell_count_r);
    end
  end

  assign lim_eff = (limit_r == '0) ? STEP_W'(1) : limit_r;

  acac_step #(
    .MAX_CELLS (MAX_CELLS),
    .ROW_LG    (ROW_LG)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .n_eff       (n_eff),
    .rule        (rule_r),
    .lim_eff     (lim_eff),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_start    (in_tdata[MAX_CELLS-1:0]),
    .in_mask     (in_tdata[2*MAX_CELLS-1:MAX_CELLS]),
    .map_busy    (map_busy),
    .map_clr     (map_clr),
    .map_rd_en   (map_rd_en),
    .map_rd_row  (map_rd_row),
    .map_rd_data (map_rd_data),
    .map_wr_en   (map_wr_en),
    .map_wr_row  (map_wr_row),
    .map_wr_data (map_wr_data),
    .q_cnt       (q_cnt),
    .push        (push),
    .push_data   (push_data)
  );

  acac_map #(
    .ROW_LG  (ROW_LG),
    .ROWS_LG (ROWS_LG)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (map_clr),
    .rd_en     (map_rd_en),
    .rd_row    (map_rd_row),
    .rd_data   (map_rd_data),
    .wr_en     (map_wr_en),
    .wr_row    (map_wr_row),
    .wr_data   (map_wr_data),
    .busy      (map_busy)
  );

  acac_outq #(
    .W (OUT_RAW)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .count     (q_cnt),
    .q_valid   (out_tvalid),
    .q_ready   (out_tready),
    .q_data    (q_data)
  );

  always_comb begin
    out_tdata              = '0;
    out_tdata[OUT_RAW-1:0] = q_data;
  end

endmodule

`default_nettype wire

// File: rtl/core/acac_chk.sv
// Port-level checker for the automaton coverage core, bound to the top level
`default_nettype none

`include "async_cellular_automaton_coverage_core_macros.svh"

module acac_chk #(
  parameter int MAX_CELLS = 12,
  localparam int OUT_RAW  = 2 * MAX_CELLS + acac_pkg::STEP_W + 3,
  localparam int OUT_DW   = ((OUT_RAW + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata
);

  localparam int CNT_LO  = MAX_CELLS;
  localparam int CNT_HI  = 2 * MAX_CELLS;
  localparam int STEP_LO = 2 * MAX_CELLS + 1;
  localparam int STEP_HI = 2 * MAX_CELLS + acac_pkg::STEP_W;

  logic                     in_acc;
  logic [CNT_HI-CNT_LO:0]   out_cnt;
  logic [STEP_HI-STEP_LO:0] out_steps;

  assign in_acc    = in_tvalid && in_tready;
  assign out_cnt   = out_tdata[CNT_HI:CNT_LO];
  assign out_steps = out_tdata[STEP_HI:STEP_LO];

  `ACAC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ACAC_ASSERT_NEXT(a_load_blocks, in_acc && (in_tuser == acac_pkg::OP_LOAD), !in_tready)
  `ACAC_ASSERT_NEXT(a_result_due, in_acc, ##1 out_tvalid)
  `ACAC_ASSERT_NOW(a_cnt_le_steps, out_tvalid, {1'b0, out_cnt} <= out_steps)

endmodule

bind async_cellular_automaton_coverage_core acac_chk #(
  .MAX_CELLS (MAX_CELLS)
) u_acac_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
